// ===== sv/evg_pkg.sv =====
// ============================================================================
// evg_pkg
// Shared types and constants of the event voxel-grid binner.
// ============================================================================
package evg_pkg;

    localparam int MAX_HEIGHT_DEF = 128;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_BINS_DEF   = 16;

    localparam int TS_W        = 63;
    localparam int PIX_W       = 16;
    localparam int BSZ_W       = 32;
    localparam int NBINS_W     = 5;
    localparam int SENS_W      = 8;
    localparam int MASK_OUT_W  = 16;
    localparam int TBIN_W      = 4;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [BSZ_W-1:0]   BIN_SIZE_RST = 32'd10000000;
    localparam logic [NBINS_W-1:0] NUM_BINS_RST = 5'd10;
    localparam logic [SENS_W-1:0]  HEIGHT_RST   = 8'd128;
    localparam logic [SENS_W-1:0]  WIDTH_RST    = 8'd128;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BIN_SIZE = 2'd0,
        REG_NUM_BINS = 2'd1,
        REG_HEIGHT   = 2'd2,
        REG_WIDTH    = 2'd3
    } t_reg_idx;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic capture;
        logic open_win;
        logic sub;
        logic close_win;
        logic clr_step;
        logic div_start;
        logic div_step;
        logic mem_rd;
        logic merge;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op_read;
        logic accumulating;
        logic close_hit;
        logic clr_last;
        logic div_last;
        logic rd_ok;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/evg_ram.sv =====
// ============================================================================
// evg_ram
// Generic single-port RAM with registered read.
// ============================================================================
module evg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/evg_ctrl.sv =====
// ============================================================================
// evg_ctrl
// Sequencer: window open/close, bank sweep, bin division, mask update.
// ============================================================================
module evg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  evg_pkg::t_sts i_sts,
    output evg_pkg::t_cmd o_cmd
);
    import evg_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_OPEN = 10'b0000000010,
        S_CHK  = 10'b0000000100,
        S_CMP  = 10'b0000001000,
        S_CLR  = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_RD   = 10'b0001000000,
        S_RDW  = 10'b0010000000,
        S_OUT  = 10'b0100000000,
        S_SPR  = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_OPEN;
                end
            end
            S_OPEN: begin
                if (i_sts.op_read) begin
                    n_state = S_RD;
                end else if (!i_sts.accumulating) begin
                    cmd.open_win = 1'b1;
                    n_state      = S_CLR;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                cmd.sub = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.close_hit) begin
                    cmd.close_win = 1'b1;
                    n_state       = S_CLR;
                end else begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_CHK;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.rd_ok) begin
                    cmd.mem_rd = 1'b1;
                    n_state    = S_RDW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RDW: begin
                cmd.merge = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

`ifndef SYNTHESIS
    a_clr_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=> (r_state == S_CLR || r_state == S_CHK))
        else $error("sweep left to wrong state");
    a_merge_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDW) |-> ($past(r_state) == S_RD))
        else $error("merge without memory read");
`endif
endmodule

// ===== sv/evg_dp.sv =====
// ============================================================================
// evg_dp
// Datapath: config registers, window timing, bin divider, occupancy banks.
// ============================================================================
module evg_dp #(
    parameter int MAX_HEIGHT = 128,
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_BINS   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [evg_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [evg_pkg::BSZ_W-1:0]              i_cfg_wdata,
    input  logic                                   i_in_op,
    input  logic [evg_pkg::IN_DATA_W-1:0]          i_in_data,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [evg_pkg::OUT_DATA_W-1:0]         o_out_data,
    input  evg_pkg::t_cmd                          i_cmd,
    output evg_pkg::t_sts                          o_sts
);
    import evg_pkg::*;

    localparam int PIX    = MAX_HEIGHT * MAX_WIDTH;
    localparam int DEPTH  = 2 * PIX;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLR_W  = (PIX > 1) ? $clog2(PIX) : 1;
    localparam int BIN_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int STEP_W = (BIN_W > 1) ? $clog2(BIN_W) : 1;
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int DUR_W  = BSZ_W + NB_W;

    logic [BSZ_W-1:0]   r_bin_size;
    logic [NBINS_W-1:0] r_num_bins;
    logic [SENS_W-1:0]  r_height;
    logic [SENS_W-1:0]  r_width;

    logic               r_op;
    logic [TS_W-1:0]    r_ts;
    logic [PIX_W-1:0]   r_x;
    logic [PIX_W-1:0]   r_y;

    logic [TS_W-1:0]    r_start;
    logic               r_acc;
    logic               r_active;
    logic               r_have_closed;

    logic [DUR_W-1:0]   r_dur;
    logic [TS_W-1:0]    r_rem;
    logic               r_neg;
    logic [BIN_W-1:0]   r_q;
    logic [STEP_W-1:0]  r_step;
    logic [CLR_W-1:0]   r_clr;

    logic               r_closed;
    logic               r_stored;
    logic               r_newly;
    logic [MASK_OUT_W-1:0] r_mask;
    logic               r_mvalid;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [BSZ_W-1:0]   bsz_eff;
    logic [NB_W-1:0]    nb_eff;
    logic [TS_W:0]      diff;
    logic [TS_W-1:0]    div_sh;
    logic [BIN_W-1:0]   bin;
    logic [BIN_W-1:0]   bin_c;
    logic               in_range;
    logic               bank;
    logic [ADDR_W-1:0]  pix_addr;
    logic [ADDR_W-1:0]  clr_addr;
    logic [ADDR_W-1:0]  ram_addr;
    logic               ram_we;
    logic [MAX_BINS-1:0] ram_wdata;
    logic [MAX_BINS-1:0] ram_rdata;
    logic [MAX_BINS-1:0] bin_bit;
    logic               out_free;

    assign bsz_eff = (r_bin_size == '0) ? BSZ_W'(1) : r_bin_size;
    assign nb_eff  = (r_num_bins == '0) ? NB_W'(1) :
                     (32'(r_num_bins) > MAX_BINS) ? NB_W'(MAX_BINS) : NB_W'(r_num_bins);

    assign diff   = {1'b0, r_ts} - {1'b0, r_start};
    assign div_sh = TS_W'(bsz_eff) << r_step;

    assign bin_c = (32'(r_q) >= 32'(nb_eff)) ? BIN_W'(nb_eff - NB_W'(1)) : r_q;
    assign bin   = (r_neg || r_op) ? '0 : bin_c;

    assign in_range = (32'(r_x) < 32'(r_width))  && (32'(r_x) < MAX_WIDTH) &&
                      (32'(r_y) < 32'(r_height)) && (32'(r_y) < MAX_HEIGHT);

    assign bank     = r_op ? ~r_active : r_active;
    assign pix_addr = (bank ? ADDR_W'(PIX) : '0) + ADDR_W'(r_y) * ADDR_W'(MAX_WIDTH)
                      + ADDR_W'(r_x);
    assign clr_addr = (r_active ? ADDR_W'(PIX) : '0) + ADDR_W'(r_clr);
    assign ram_addr = i_cmd.clr_step ? clr_addr : pix_addr;
    assign bin_bit  = MAX_BINS'(1) << bin;
    assign ram_we   = i_cmd.clr_step || (i_cmd.merge && (r_op == OP_EVENT));
    assign ram_wdata = i_cmd.clr_step ? '0 : (ram_rdata | bin_bit);

    evg_ram #(
        .WIDTH (MAX_BINS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_size <= BIN_SIZE_RST;
            r_num_bins <= NUM_BINS_RST;
            r_height   <= HEIGHT_RST;
            r_width    <= WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_BIN_SIZE: r_bin_size <= i_cfg_wdata;
                REG_NUM_BINS: r_num_bins <= i_cfg_wdata[NBINS_W-1:0];
                REG_HEIGHT:   r_height   <= i_cfg_wdata[SENS_W-1:0];
                REG_WIDTH:    r_width    <= i_cfg_wdata[SENS_W-1:0];
                default: ;
            endcase
        end
    end

    // window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= 1'b0;
            r_active      <= 1'b0;
            r_have_closed <= 1'b0;
            r_start       <= '0;
        end else if (i_cmd.open_win) begin
            r_acc   <= 1'b1;
            r_start <= r_ts;
        end else if (i_cmd.close_win) begin
            r_active      <= ~r_active;
            r_have_closed <= 1'b1;
            r_start       <= r_ts;
        end
    end

    // item payload and working registers
    always_ff @(posedge i_clk) begin
        r_dur <= DUR_W'(nb_eff) * DUR_W'(bsz_eff);
        if (i_cmd.capture) begin
            r_op     <= i_in_op;
            r_ts     <= i_in_data[TS_W-1:0];
            r_x      <= i_in_data[TS_W +: PIX_W];
            r_y      <= i_in_data[TS_W+PIX_W +: PIX_W];
            r_closed <= 1'b0;
            r_stored <= 1'b0;
            r_newly  <= 1'b0;
            r_mask   <= '0;
            r_mvalid <= 1'b0;
            r_neg    <= 1'b0;
            r_q      <= '0;
        end
        if (i_cmd.open_win || i_cmd.close_win) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + CLR_W'(1);
        end
        if (i_cmd.close_win) begin
            r_closed <= 1'b1;
        end
        if (i_cmd.sub) begin
            r_rem <= diff[TS_W-1:0];
            r_neg <= diff[TS_W];
        end
        if (i_cmd.div_start) begin
            r_q    <= '0;
            r_step <= STEP_W'(BIN_W - 1);
        end else if (i_cmd.div_step) begin
            if (r_rem >= div_sh) begin
                r_rem <= r_rem - div_sh;
                r_q   <= r_q | (BIN_W'(1) << r_step);
            end
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.merge) begin
            if (r_op == OP_READ) begin
                r_mask   <= MASK_OUT_W'(ram_rdata);
                r_mvalid <= 1'b1;
            end else begin
                r_stored <= 1'b1;
                r_newly  <= ((ram_rdata & bin_bit) == '0);
            end
        end
    end

    // result register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_mvalid, r_mask, r_newly, r_stored, TBIN_W'(bin), r_closed};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.op_read      = r_op;
    assign o_sts.accumulating = r_acc;
    assign o_sts.close_hit    = !r_neg && (r_rem >= TS_W'(r_dur));
    assign o_sts.clr_last     = (32'(r_clr) == PIX - 1);
    assign o_sts.div_last     = (r_step == '0);
    assign o_sts.rd_ok        = in_range && (r_op == OP_EVENT || r_have_closed);
    assign o_sts.out_free     = out_free;

`ifndef SYNTHESIS
    a_newly_needs_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_data[6] || r_out_data[5]))
        else $error("newly_set without stored");
    a_kinds_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[23] && r_out_data[5]))
        else $error("read and event fields both set");
    a_read_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.merge && r_op == OP_READ) |-> r_have_closed)
        else $error("mask read before any closed window");
`endif
endmodule

// ===== sv/event_voxel_grid_binner.sv =====
// ============================================================================
// event_voxel_grid_binner
// Bins camera events into time-bin occupancy masks with ping-pong banks.
// ============================================================================
// One item at a time. A valid read reads the mask RAM and merges the word
// into the result; it skips the RAM read when no closed window exists or the
// address is out of range. An event takes a subtract, a window compare, the
// one-bit-per-cycle bin divider and the read-modify-write of the single-port
// mask RAM, and skips the RAM access when it lies outside the sensor. The
// event that opens the first window and an event that closes a window also
// run the zeroing sweep of the new active bank, one RAM word per cycle. A
// finished result waits in an output register while the next word is taken;
// a result that is still waiting when the next one is ready holds the block.
module event_voxel_grid_binner #(
    parameter int MAX_HEIGHT = evg_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH  = evg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_BINS   = evg_pkg::MAX_BINS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [evg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [evg_pkg::BSZ_W-1:0]      i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // timestamp_ns[62:0], pixel_x[78:63], pixel_y[94:79], zero[95]
    input  logic [evg_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // window_closed[0], bin_idx[4:1], stored[5], newly_set[6],
    // bin_mask[22:7], mask_valid[23]
    output logic [evg_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import evg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    evg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    evg_dp #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_BINS   (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_op     (i_s_axis_tuser),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule
